// ===== design/tqc_pkg.sv =====
// Shared types and constants for the two-queue block cache directory.
// No dependencies; used by tqc_cell and two_queue_block_cache_policy_core.
package tqc_pkg;

    localparam logic [1:0] KIND_HIT       = 2'd0;
    localparam logic [1:0] KIND_WRITEBACK = 2'd1;
    localparam logic [1:0] KIND_LOAD      = 2'd2;
    localparam logic [1:0] KIND_FLUSHED   = 2'd3;

    localparam logic [1:0] PROMOTE_HITS = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [15:0] file;
        logic [31:0] block;
        logic        dirty;
        logic        prot;
        logic [1:0]  hits;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_FROM_PREV = 2'd1,
        CELL_FROM_NEXT = 2'd2,
        CELL_CLEAR     = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic [15:0] key_file;
        logic [31:0] key_block;
    } cell_ctl_t;

endpackage

// ===== design/tqc_cell.sv =====
// One directory cell: holds an entry and its slot, compares it with the key.
// Depends on tqc_pkg.
module tqc_cell
    import tqc_pkg::*;
#(
    parameter int SLOT_W = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctl_t         ctl,
    input  entry_t            prev_ent,
    input  logic [SLOT_W-1:0] prev_slot,
    input  entry_t            next_ent,
    input  logic [SLOT_W-1:0] next_slot,
    output entry_t            ent,
    output logic [SLOT_W-1:0] ent_slot,
    output logic              match
);

    entry_t            ent_reg;
    entry_t            ent_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;

    always_comb
    begin
        ent_next  = ent_reg;
        slot_next = slot_reg;
        case (ctl.op)
            CELL_HOLD:
            begin
                ent_next  = ent_reg;
            end
            CELL_FROM_PREV:
            begin
                ent_next  = prev_ent;
                slot_next = prev_slot;
            end
            CELL_FROM_NEXT:
            begin
                ent_next  = next_ent;
                slot_next = next_slot;
            end
            CELL_CLEAR:
            begin
                ent_next.valid = 1'b0;
            end
            default:
            begin
                ent_next  = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg  <= '0;
            slot_reg <= '0;
        end
        else
        begin
            ent_reg  <= ent_next;
            slot_reg <= slot_next;
        end
    end

    assign ent      = ent_reg;
    assign ent_slot = slot_reg;
    assign match    = ent_reg.valid && (ent_reg.file == ctl.key_file)
                      && (ent_reg.block == ctl.key_block);

endmodule

// ===== design/two_queue_block_cache_policy_core.sv =====
// Two-queue block cache directory: a chain of cells kept in recency order,
// most recently touched entry in cell 0. Depends on tqc_pkg and tqc_cell.
// A hit or a load with room passes through acceptance, the parallel tag compare
// and the chain update before the next request is accepted. A flush, or a miss
// on a full directory, walks the chain twice by rotation (probation, then
// protected), held up only while the output stalls.
// Each request gives its results in order; the last carries last = 1.
module two_queue_block_cache_policy_core
    import tqc_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [15:0] file_id,
    input  logic [31:0] block_offset,
    input  logic        is_write,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [15:0] out_file_id,
    output logic [31:0] out_block_offset,
    output logic [3:0]  slot,
    output logic        last
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(CAPACITY);
    localparam logic [SLOT_W-1:0] STEP_LAST = SLOT_W'(CAPACITY - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOOK  = 5'b00010,
        S_ACT   = 5'b00100,
        S_FLUSH = 5'b01000,
        S_FIN   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic              req_action_reg;
    logic [15:0]       req_file_reg;
    logic [31:0]       req_block_reg;
    logic              req_write_reg;
    logic [CAPACITY-1:0] match_reg, match_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] step_reg, step_next;
    logic              pass_reg, pass_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic [15:0]       ofile_reg, ofile_next;
    logic [31:0]       oblock_reg, oblock_next;
    logic [3:0]        slot_reg, slot_next;
    logic              last_reg, last_next;

    entry_t            ents [CAPACITY];
    logic [SLOT_W-1:0] slots [CAPACITY];
    cell_ctl_t         ctls [CAPACITY];
    cell_op_t          ops [CAPACITY];
    logic [CAPACITY-1:0] match_w;
    logic [CAPACITY-1:0] upto_hit;
    logic [CAPACITY-1:0] valid_vec;

    entry_t            new_ent;
    logic [SLOT_W-1:0] new_slot;
    entry_t            hit_ent;
    logic [SLOT_W-1:0] hit_slot;
    entry_t            load_ent;
    logic              out_free;
    logic              emit;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            assign ctls[g].op        = ops[g];
            assign ctls[g].key_file  = req_file_reg;
            assign ctls[g].key_block = req_block_reg;
            assign upto_hit[g]       = |(match_reg >> g);
            assign valid_vec[g]      = ents[g].valid;
            tqc_cell #(.SLOT_W(SLOT_W)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctls[g]),
                .prev_ent  ((g == 0) ? new_ent : ents[(g + CAPACITY - 1) % CAPACITY]),
                .prev_slot ((g == 0) ? new_slot : slots[(g + CAPACITY - 1) % CAPACITY]),
                .next_ent  (ents[(g + 1) % CAPACITY]),
                .next_slot (slots[(g + 1) % CAPACITY]),
                .ent       (ents[g]),
                .ent_slot  (slots[g]),
                .match     (match_w[g])
            );
        end
    endgenerate

    // matched entry, one-hot select
    always_comb
    begin
        hit_ent  = '0;
        hit_slot = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_reg[i])
            begin
                hit_ent  = hit_ent | ents[i];
                hit_slot = hit_slot | slots[i];
            end
        end
    end

    always_comb
    begin
        load_ent.valid = 1'b1;
        load_ent.file  = req_file_reg;
        load_ent.block = req_block_reg;
        load_ent.dirty = req_write_reg;
        load_ent.prot  = 1'b0;
        load_ent.hits  = 2'd0;
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = ents[0].valid && ents[0].dirty && (ents[0].prot == pass_reg);

    always_comb
    begin
        state_next     = state_reg;
        match_next     = match_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        ofile_next     = ofile_reg;
        oblock_next    = oblock_reg;
        slot_next      = slot_reg;
        last_next      = last_reg;
        new_ent        = load_ent;
        new_slot       = SLOT_W'(count_reg);
        for (int i = 0; i < CAPACITY; i++)
        begin
            ops[i] = CELL_HOLD;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                match_next = match_w;
                state_next = S_ACT;
            end
            S_ACT:
            begin
                if (out_free)
                begin
                    if (req_action_reg || (!(|match_reg) && count_reg == CNT_FULL))
                    begin
                        step_next  = '0;
                        pass_next  = 1'b0;
                        state_next = S_FLUSH;
                    end
                    else if (|match_reg)
                    begin
                        // move the hit entry to the head, cells above it shift down
                        new_ent  = hit_ent;
                        new_slot = hit_slot;
                        if (!hit_ent.prot)
                        begin
                            new_ent.hits = hit_ent.hits + 2'd1;
                            new_ent.prot = (new_ent.hits == PROMOTE_HITS);
                        end
                        new_ent.dirty = hit_ent.dirty | req_write_reg;
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            ops[i] = upto_hit[i] ? CELL_FROM_PREV : CELL_HOLD;
                        end
                        out_valid_next = 1'b1;
                        kind_next      = KIND_HIT;
                        ofile_next     = req_file_reg;
                        oblock_next    = req_block_reg;
                        slot_next      = 4'(hit_slot);
                        last_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            ops[i] = CELL_FROM_PREV;
                        end
                        count_next     = count_reg + CNT_W'(1);
                        out_valid_next = 1'b1;
                        kind_next      = KIND_LOAD;
                        ofile_next     = req_file_reg;
                        oblock_next    = req_block_reg;
                        slot_next      = 4'(SLOT_W'(count_reg));
                        last_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!emit || out_free)
                begin
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_WRITEBACK;
                        ofile_next     = ents[0].file;
                        oblock_next    = ents[0].block;
                        slot_next      = 4'(slots[0]);
                        last_next      = 1'b0;
                    end
                    if (step_reg == STEP_LAST && pass_reg)
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            ops[i] = CELL_CLEAR;
                        end
                        count_next = '0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        // rotate toward the head
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            ops[i] = CELL_FROM_NEXT;
                        end
                        if (step_reg == STEP_LAST)
                        begin
                            step_next = '0;
                            pass_next = 1'b1;
                        end
                        else
                        begin
                            step_next = step_reg + SLOT_W'(1);
                        end
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    if (req_action_reg)
                    begin
                        kind_next   = KIND_FLUSHED;
                        ofile_next  = '0;
                        oblock_next = '0;
                        slot_next   = '0;
                    end
                    else
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            ops[i] = CELL_FROM_PREV;
                        end
                        count_next  = count_reg + CNT_W'(1);
                        kind_next   = KIND_LOAD;
                        ofile_next  = req_file_reg;
                        oblock_next = req_block_reg;
                        slot_next   = 4'(SLOT_W'(count_reg));
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            pass_reg      <= 1'b0;
            match_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            pass_reg      <= pass_next;
            match_reg     <= match_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            req_action_reg <= action;
            req_file_reg   <= file_id;
            req_block_reg  <= block_offset;
            req_write_reg  <= is_write;
        end
        kind_reg   <= kind_next;
        ofile_reg  <= ofile_next;
        oblock_reg <= oblock_next;
        slot_reg   <= slot_next;
        last_reg   <= last_next;
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign kind             = kind_reg;
    assign out_file_id      = ofile_reg;
    assign out_block_offset = oblock_reg;
    assign slot             = slot_reg;
    assign last             = last_reg;

    // a key lives in at most one cell
    a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACT) |-> $onehot0(match_reg))
        else $error("multiple tag matches");

    // fill count tracks the valid cells between requests
    a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(valid_vec) == 32'(count_reg)))
        else $error("entry count out of step with valid cells");

    // valid cells are packed at the head of the chain when idle
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (valid_vec == CAPACITY'((1 << count_reg) - 1)))
        else $error("valid cells not contiguous");

    // flush leaves the directory empty
    a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (valid_vec == '0 && count_reg == '0))
        else $error("directory not empty after flush");

endmodule

// ===== tb/tb_two_queue_block_cache_policy_core.sv =====
// Testbench for two_queue_block_cache_policy_core: directed table plus random
// access/flush traffic, every result checked against an in-bench cache model.
// Depends on tqc_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_two_queue_block_cache_policy_core;
    import tqc_pkg::*;

    localparam int DEPTH = 16;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] file;
        logic [31:0] block;
        logic [3:0]  slot;
        logic        last;
    } cache_result_t;

    typedef struct {
        logic        flush;
        logic [15:0] file;
        logic [31:0] block;
        logic        wr;
        logic        known;
        logic [1:0]  kind;
        logic [3:0]  slot;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        action = 1'b0;
    logic [15:0] file_id = '0;
    logic [31:0] block_offset = '0;
    logic        is_write = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [15:0] out_file_id;
    logic [31:0] out_block_offset;
    logic [3:0]  slot;
    logic        last;

    two_queue_block_cache_policy_core #(.CAPACITY(DEPTH)) dut (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    // cache directory model
    logic        m_valid [DEPTH];
    logic [15:0] m_file  [DEPTH];
    logic [31:0] m_block [DEPTH];
    logic        m_dirty [DEPTH];
    logic        m_prot  [DEPTH];
    logic [1:0]  m_hits  [DEPTH];
    logic [31:0] m_stamp [DEPTH];
    logic [31:0] touches = '0;
    int          fill = 0;

    cache_result_t pending_results[$];
    cache_result_t last_pred;
    int          errors = 0;
    int          idle_cycles = 0;
    bit          busy_phase = 0;

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            m_valid[i] = 1'b0;
    end

    function automatic void push_result(logic [1:0] k, logic [15:0] f, logic [31:0] b,
                                        int s, logic l);
        cache_result_t r;
        r.kind = k; r.file = f; r.block = b; r.slot = s[3:0]; r.last = l;
        pending_results.push_back(r);
        last_pred = r;
    endfunction

    // write back dirty entries, probation group first, most recent first
    function automatic void flush_directory();
        int order[DEPTH];
        int n;
        int j;
        for (int grp = 0; grp < 2; grp++)
        begin
            n = 0;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (m_valid[i] && m_prot[i] == grp[0])
                begin
                    j = n;
                    while (j > 0 && (touches - m_stamp[order[j-1]]) > (touches - m_stamp[i]))
                    begin
                        order[j] = order[j-1];
                        j--;
                    end
                    order[j] = i;
                    n++;
                end
            end
            for (j = 0; j < n; j++)
                if (m_dirty[order[j]])
                    push_result(KIND_WRITEBACK, m_file[order[j]], m_block[order[j]],
                                order[j], 1'b0);
        end
        for (int i = 0; i < DEPTH; i++)
            m_valid[i] = 1'b0;
        fill = 0;
    endfunction

    function automatic void predict_access(logic fl, logic [15:0] f, logic [31:0] b,
                                           logic wr);
        int s;
        if (fl)
        begin
            flush_directory();
            push_result(KIND_FLUSHED, '0, '0, 0, 1'b1);
            return;
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            if (m_valid[i] && m_file[i] == f && m_block[i] == b)
            begin
                if (!m_prot[i])
                begin
                    m_hits[i] = m_hits[i] + 2'd1;
                    if (m_hits[i] == PROMOTE_HITS)
                        m_prot[i] = 1'b1;
                end
                touches = touches + 1;
                m_stamp[i] = touches;
                if (wr)
                    m_dirty[i] = 1'b1;
                push_result(KIND_HIT, f, b, i, 1'b1);
                return;
            end
        end
        if (fill >= DEPTH)
            flush_directory();
        s = fill;
        m_valid[s] = 1'b1; m_file[s] = f; m_block[s] = b; m_dirty[s] = wr;
        m_prot[s] = 1'b0; m_hits[s] = 2'd0;
        touches = touches + 1;
        m_stamp[s] = touches;
        fill = s + 1;
        push_result(KIND_LOAD, f, b, s, 1'b1);
    endfunction

    // drive one request from the current edge and hold it until accepted
    task automatic send_request(logic fl, logic [15:0] f, logic [31:0] b, logic wr);
        int gap;
        in_valid <= 1'b1;
        action <= fl; file_id <= f; block_offset <= b; is_write <= wr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_access(fl, f, b, wr);
        gap = busy_phase ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result check and receiver stalls
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result kind=%0d file=%h block=%h slot=%0d",
                             kind, out_file_id, out_block_offset, slot);
            end
            else
            begin
                cache_result_t e;
                e = pending_results.pop_front();
                if (e.kind !== kind || e.file !== out_file_id || e.block !== out_block_offset
                    || e.slot !== slot || e.last !== last)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch exp k=%0d f=%h b=%h s=%0d l=%b ",
                                  "got k=%0d f=%h b=%h s=%0d l=%b"},
                                 e.kind, e.file, e.block, e.slot, e.last,
                                 kind, out_file_id, out_block_offset, slot, last);
                end
            end
            stall_left = busy_phase ? 0 : $urandom_range(0, 18);
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    dir_row_t rows[] = '{
        '{1'b1, 16'h0000, 32'h0000_0000, 1'b1, 1'b1, KIND_FLUSHED, 4'd0},
        '{1'b0, 16'h0000, 32'h0000_0000, 1'b0, 1'b1, KIND_LOAD, 4'd0},
        '{1'b0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, KIND_LOAD, 4'd1},
        '{1'b0, 16'h0000, 32'h0000_0000, 1'b0, 1'b1, KIND_HIT, 4'd0},
        '{1'b0, 16'h0000, 32'h0000_0000, 1'b0, 1'b1, KIND_HIT, 4'd0},
        '{1'b0, 16'h0000, 32'h0000_0000, 1'b1, 1'b1, KIND_HIT, 4'd0},
        '{1'b0, 16'hA5A5, 32'h5A5A_5A5A, 1'b1, 1'b1, KIND_LOAD, 4'd2},
        '{1'b0, 16'hFFFF, 32'h0000_0000, 1'b0, 1'b1, KIND_LOAD, 4'd3},
        '{1'b0, 16'h0000, 32'hFFFF_FFFF, 1'b1, 1'b1, KIND_LOAD, 4'd4},
        '{1'b0, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, KIND_HIT, 4'd1},
        '{1'b0, 16'hA5A5, 32'h5A5A_5A5A, 1'b0, 1'b1, KIND_HIT, 4'd2},
        '{1'b0, 16'hA5A5, 32'h5A5A_5A5A, 1'b0, 1'b0, KIND_HIT, 4'd0},
        '{1'b1, 16'h1234, 32'h8765_4321, 1'b0, 1'b0, KIND_FLUSHED, 4'd0},
        '{1'b1, 16'h0000, 32'h0000_0000, 1'b0, 1'b1, KIND_FLUSHED, 4'd0},
        '{1'b0, 16'h5A5A, 32'hA5A5_A5A5, 1'b1, 1'b1, KIND_LOAD, 4'd0}
    };

    logic [15:0] pool_file  [24];
    logic [31:0] pool_block [24];

    initial
    begin
        int     pick;
        int     sel;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r])
        begin
            send_request(rows[r].flush, rows[r].file, rows[r].block, rows[r].wr);
            // last prediction of the row is its final result
            if (rows[r].known && (last_pred.kind !== rows[r].kind
                                  || last_pred.slot !== rows[r].slot))
            begin
                errors++;
                if (errors <= 10)
                    $display("row %0d: table expects k=%0d s=%0d", r, rows[r].kind,
                             rows[r].slot);
            end
        end

        // more keys than slots so the directory fills and spills often
        for (int i = 0; i < 24; i++)
        begin
            pool_file[i] = 16'($urandom);
            pool_block[i] = $urandom;
        end
        for (int n = 0; n < 320; n++)
        begin
            if (n % 40 == 0)
                busy_phase = ($urandom_range(0, 3) == 0);
            if (n == 160)
            begin
                // hold off until the core has drained completely
                in_valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
                repeat (DRAIN_CYCLES) @(posedge clk);
            end
            sel = $urandom_range(0, 99);
            if (sel < 4)
                send_request(1'b1, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
            else if (sel < 14)
                send_request(1'b0, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
            else
            begin
                // bias toward a few hot keys so entries get promoted
                pick = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 5)
                                                   : $urandom_range(0, 23);
                send_request(1'b0, pool_file[pick], pool_block[pick],
                             1'($urandom_range(0, 1)));
            end
        end
        in_valid <= 1'b0;
        busy_phase = 0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== two_queue_block_cache_policy_core.f =====
design/tqc_pkg.sv
design/tqc_cell.sv
design/two_queue_block_cache_policy_core.sv
tb/tb_two_queue_block_cache_policy_core.sv
